// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl
// expects a clock named clk and an active-low reset named arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/lacptrl_pkg.sv =====
// types, codes and control store for the lacp transmit rate limiter
// no dependencies
package lacptrl_pkg;

	localparam int unsigned MAX_RUN_STEPS_DEF = 10;

	localparam int unsigned CNT_W   = 4;
	localparam int unsigned TIMER_W = 8;
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// commands
	localparam logic [1:0] CMD_RUN   = 2'd0;
	localparam logic [1:0] CMD_TICK  = 2'd1;
	localparam logic [1:0] CMD_RESET = 2'd2;

	// machine states
	localparam logic [1:0] ST_NO_TX       = 2'd0;
	localparam logic [1:0] ST_RESET_COUNT = 2'd1;
	localparam logic [1:0] ST_TX_PDU      = 2'd2;
	localparam logic [1:0] ST_INVALID     = 2'd3;

	// register indexes
	localparam logic REG_TX_LIMIT    = 1'b0;
	localparam logic REG_TX_INTERVAL = 1'b1;

	localparam logic [3:0]         TX_LIMIT_RST    = 4'd3;
	localparam logic [TIMER_W-1:0] TX_INTERVAL_RST = 8'd10;

	typedef struct packed {
		logic [1:0] command;
		logic       tx_enabled;
		logic       ntt_request;
		logic       mac_operational;
		logic       single_step;
	} in_item_t;

	typedef struct packed {
		logic [1:0]       tx_state;
		logic             pdu_sent;
		logic [3:0]       transitions;
		logic             ntt_pending;
		logic [CNT_W-1:0] sent_count;
	} out_item_t;

	// microprogram addresses
	localparam int unsigned UPC_W = 3;
	localparam logic [UPC_W-1:0] U_IDLE  = 3'd0;
	localparam logic [UPC_W-1:0] U_PREP  = 3'd1;
	localparam logic [UPC_W-1:0] U_STEP  = 3'd2;
	localparam logic [UPC_W-1:0] U_TICK  = 3'd3;
	localparam logic [UPC_W-1:0] U_CLEAR = 3'd4;
	localparam logic [UPC_W-1:0] U_EMIT  = 3'd5;

	// datapath operations
	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] OP_PREP  = 3'd1;
	localparam logic [2:0] OP_STEP  = 3'd2;
	localparam logic [2:0] OP_TICK  = 3'd3;
	localparam logic [2:0] OP_CLEAR = 3'd4;
	localparam logic [2:0] OP_EMIT  = 3'd5;

	// jump kinds
	localparam logic [1:0] J_GOTO     = 2'd0;
	localparam logic [1:0] J_DISPATCH = 2'd1;
	localparam logic [1:0] J_LOOP     = 2'd2;
	localparam logic [1:0] J_OUTFREE  = 2'd3;

	typedef struct packed {
		logic [2:0]       op;
		logic [1:0]       jmp;
		logic [UPC_W-1:0] target;
	} ucw_t;

	function automatic ucw_t ucode_rom(input logic [UPC_W-1:0] addr);
		ucw_t w;
		unique case (addr)
			U_IDLE:  w = '{op: OP_NONE,  jmp: J_DISPATCH, target: U_IDLE};
			U_PREP:  w = '{op: OP_PREP,  jmp: J_GOTO,     target: U_STEP};
			U_STEP:  w = '{op: OP_STEP,  jmp: J_LOOP,     target: U_EMIT};
			U_TICK:  w = '{op: OP_TICK,  jmp: J_GOTO,     target: U_EMIT};
			U_CLEAR: w = '{op: OP_CLEAR, jmp: J_GOTO,     target: U_EMIT};
			U_EMIT:  w = '{op: OP_EMIT,  jmp: J_OUTFREE,  target: U_IDLE};
			default: w = '{op: OP_NONE,  jmp: J_GOTO,     target: U_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ===== hw/rtl/lacp_transmit_rate_limiter_unit.sv =====
// lacp transmit rate limiter: microcoded sequencer with its datapath
// depends on lacptrl_pkg and assert_macros.svh
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+---------------------
//  in       | input     | in_valid/in_stall | in_item (in_item_t)
//  out      | output    | out_valid/out_stall | out_item (out_item_t)
//  config   | input     | apb psel/penable  | tx_limit, tx_interval
//
// a run item passes prep, then a step per transition taken (0..MAX_RUN_STEPS)
// plus one that finds none, unless the step limit or single step ends the run,
// then emit; tick and reset items pass tick or clear, unused commands neither,
// then emit; one item is worked on at a time; the next is taken once the result
// is in the output register, which holds it while out_stall is high
// reset puts the machine in no-transmit with all counts cleared
`include "assert_macros.svh"

module lacp_transmit_rate_limiter_unit
	import lacptrl_pkg::*;
#(
	parameter int unsigned MAX_RUN_STEPS = MAX_RUN_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_item,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned STEP_W = $clog2(MAX_RUN_STEPS + 1);
	localparam int unsigned SAT_W  = (STEP_W > 4) ? STEP_W : 4;

	logic [UPC_W-1:0]   upc_q, upc_d;
	ucw_t               ucw;
	in_item_t           item_q;
	logic [1:0]         mstate_q, mstate_d;
	logic               ntt_q, ntt_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic [TIMER_W-1:0] timer_q, timer_d;
	logic               sent_q, sent_d;
	logic [STEP_W-1:0]  steps_q, steps_d;
	logic [3:0]         tx_limit_q;
	logic [TIMER_W-1:0] tx_interval_q;
	logic               out_valid_q;
	out_item_t          out_item_q;

	logic               in_acc, out_free, cfg_wr;
	logic               taken, step_sent, loop_on;
	logic [1:0]         st_n;
	logic               ntt_n;
	logic [CNT_W-1:0]   cnt_n;
	logic [TIMER_W-1:0] timer_n;
	logic [SAT_W-1:0]   steps_ext;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_limit_q    <= TX_LIMIT_RST;
			tx_interval_q <= TX_INTERVAL_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_TX_LIMIT:    tx_limit_q    <= pwdata[3:0];
				REG_TX_INTERVAL: tx_interval_q <= pwdata[TIMER_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_TX_LIMIT:    prdata = 32'(tx_limit_q);
			REG_TX_INTERVAL: prdata = 32'(tx_interval_q);
			default: ;
		endcase
	end

	// control store
	assign ucw      = ucode_rom(upc_q);
	assign in_stall = (upc_q != U_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// one transition of the machine
	always_comb begin
		taken     = 1'b0;
		step_sent = 1'b0;
		st_n      = mstate_q;
		ntt_n     = ntt_q;
		cnt_n     = cnt_q;
		timer_n   = timer_q;
		priority if (mstate_q != ST_NO_TX && !item_q.tx_enabled) begin
			taken = 1'b1;
			st_n = ST_NO_TX; ntt_n = 1'b0; cnt_n = '0; timer_n = '0;
		end else begin
			unique case (mstate_q)
				ST_NO_TX: begin
					if (!item_q.tx_enabled && ntt_q) begin
						taken = 1'b1;
						st_n = ST_NO_TX; ntt_n = 1'b0; cnt_n = '0; timer_n = '0;
					end else if (item_q.tx_enabled) begin
						taken = 1'b1;
						st_n = ST_RESET_COUNT; cnt_n = '0;
					end
				end
				ST_RESET_COUNT, ST_TX_PDU: begin
					if (ntt_q && (mstate_q == ST_RESET_COUNT ||
							cnt_q < tx_limit_q)) begin
						taken = 1'b1;
						st_n = ST_TX_PDU;
						if (item_q.mac_operational) begin
							step_sent = 1'b1;
							ntt_n = 1'b0;
							if (timer_q == '0) begin
								timer_n = tx_interval_q;
								cnt_n = CNT_W'(1);
							end else if (cnt_q != CNT_MAX) begin
								cnt_n = cnt_q + CNT_W'(1);
							end
						end
					end else if (mstate_q == ST_TX_PDU && timer_q == '0) begin
						taken = 1'b1;
						st_n = ST_RESET_COUNT; cnt_n = '0;
					end
				end
				default: begin
					taken = 1'b1;
					st_n = ST_NO_TX; ntt_n = 1'b0; cnt_n = '0; timer_n = '0;
				end
			endcase
		end
	end

	assign loop_on = taken && !item_q.single_step &&
		((STEP_W + 1)'(steps_q) + (STEP_W + 1)'(1) < (STEP_W + 1)'(MAX_RUN_STEPS));

	// sequencer
	always_comb begin
		upc_d = ucw.target;
		unique case (ucw.jmp)
			J_GOTO: upc_d = ucw.target;
			J_DISPATCH: begin
				if (in_acc) begin
					unique case (in_item.command)
						CMD_RUN:   upc_d = U_PREP;
						CMD_TICK:  upc_d = U_TICK;
						CMD_RESET: upc_d = U_CLEAR;
						default:   upc_d = U_EMIT;
					endcase
				end else begin
					upc_d = upc_q;
				end
			end
			J_LOOP:    upc_d = loop_on ? upc_q : ucw.target;
			J_OUTFREE: upc_d = out_free ? ucw.target : upc_q;
			default:   upc_d = U_IDLE;
		endcase
	end

	// datapath
	always_comb begin
		mstate_d = mstate_q;
		ntt_d    = ntt_q;
		cnt_d    = cnt_q;
		timer_d  = timer_q;
		sent_d   = sent_q;
		steps_d  = steps_q;
		unique case (ucw.op)
			OP_NONE: begin
				if (in_acc) begin
					sent_d  = 1'b0;
					steps_d = '0;
				end
			end
			OP_PREP: begin
				if (item_q.ntt_request) ntt_d = 1'b1;
			end
			OP_STEP: begin
				if (taken) begin
					mstate_d = st_n;
					ntt_d    = ntt_n;
					cnt_d    = cnt_n;
					timer_d  = timer_n;
					sent_d   = sent_q | step_sent;
					steps_d  = steps_q + STEP_W'(1);
				end
			end
			OP_TICK: begin
				if (timer_q != '0) timer_d = timer_q - TIMER_W'(1);
			end
			OP_CLEAR: begin
				mstate_d = ST_NO_TX;
				ntt_d    = 1'b0;
				cnt_d    = '0;
				timer_d  = '0;
			end
			OP_EMIT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q    <= U_IDLE;
			mstate_q <= ST_NO_TX;
			ntt_q    <= 1'b0;
			cnt_q    <= '0;
			timer_q  <= '0;
			sent_q   <= 1'b0;
			steps_q  <= '0;
		end else begin
			upc_q    <= upc_d;
			mstate_q <= mstate_d;
			ntt_q    <= ntt_d;
			cnt_q    <= cnt_d;
			timer_q  <= timer_d;
			sent_q   <= sent_d;
			steps_q  <= steps_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) item_q <= in_item;
	end

	// output register
	assign steps_ext = SAT_W'(steps_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ucw.op == OP_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ucw.op == OP_EMIT && out_free) begin
			out_item_q.tx_state    <= mstate_q;
			out_item_q.pdu_sent    <= sent_q;
			out_item_q.transitions <= (steps_ext > SAT_W'(15)) ? 4'd15 : steps_ext[3:0];
			out_item_q.ntt_pending <= ntt_q;
			out_item_q.sent_count  <= cnt_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	`ASSERT_ALWAYS(a_steps_bound, steps_q <= STEP_W'(MAX_RUN_STEPS), "run step count overran")
	`ASSERT_ALWAYS(a_state_code, mstate_q != ST_INVALID, "machine reached invalid state code")
	`ASSERT_ALWAYS(a_sent_clears_ntt, !(out_valid_q && out_item_q.pdu_sent &&
		out_item_q.ntt_pending), "pdu sent but need-to-transmit still set")
	`ASSERT_NEXT(a_emit_loads, ucw.op == OP_EMIT && out_free, out_valid_q && upc_q == U_IDLE,
		"result not loaded on emit")

endmodule

// ===== test/tb_lacp_transmit_rate_limiter_unit.sv =====
// testbench for lacp_transmit_rate_limiter_unit: directed table, then random items
// under several register settings and idle patterns, checked against the table's known results or a built-in predictor
// depends on lacptrl_pkg and the rtl of the unit
module tb_lacp_transmit_rate_limiter_unit;
	import lacptrl_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [2:0] ADDR_TX_LIMIT = {REG_TX_LIMIT, 2'b00};
	localparam logic [2:0] ADDR_TX_INTERVAL = {REG_TX_INTERVAL, 2'b00};
	localparam int QUIET_LIMIT = 3000;
	localparam int DIR_ROWS = 25;
	localparam int PHASES = 5;
	localparam int ITEMS_PER_PHASE = 200;
	localparam out_item_t RESULT_AT_REST = '0;

	typedef struct packed {
		in_item_t  stim;
		logic      known;
		out_item_t want;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_item = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_item;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// predictor copy of the machine and its registers
	logic [1:0]         lim_state;
	logic               lim_ntt;
	logic [CNT_W-1:0]   lim_count;
	logic [TIMER_W-1:0] lim_timer;
	logic               step_sent;
	logic [3:0]         cfg_tx_limit;
	logic [TIMER_W-1:0] cfg_interval;

	out_item_t expected_results[$];
	int mismatches = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	stim_row_t directed_rows [DIR_ROWS] = '{
		'{'{CMD_TICK,   1'b1, 1'b1, 1'b1, 1'b1}, 1'b1, RESULT_AT_REST},
		'{'{CMD_UNUSED, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b1, RESULT_AT_REST},
		'{'{CMD_RUN,    1'b0, 1'b0, 1'b1, 1'b1}, 1'b1, RESULT_AT_REST},
		'{'{CMD_RUN,    1'b0, 1'b1, 1'b0, 1'b0}, 1'b1,
			'{ST_NO_TX, 1'b0, 4'd1, 1'b0, 4'd0}},
		'{'{CMD_RESET,  1'b1, 1'b1, 1'b1, 1'b1}, 1'b1, RESULT_AT_REST},
		'{'{CMD_RUN,    1'b1, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
		'{'{CMD_RUN,    1'b1, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
		'{'{CMD_RUN,    1'b1, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
		'{'{CMD_RUN,    1'b1, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
		'{'{CMD_RUN,    1'b1, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
		'{'{CMD_RUN,    1'b1, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
		'{'{CMD_TICK,   1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{CMD_TICK,   1'b1, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
		'{'{CMD_TICK,   1'b0, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
		'{'{CMD_TICK,   1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
		'{'{CMD_TICK,   1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
		'{'{CMD_TICK,   1'b1, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
		'{'{CMD_TICK,   1'b0, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
		'{'{CMD_TICK,   1'b1, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
		'{'{CMD_TICK,   1'b0, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
		'{'{CMD_TICK,   1'b1, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
		'{'{CMD_TICK,   1'b0, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
		'{'{CMD_RUN,    1'b1, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
		'{'{CMD_RUN,    1'b0, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
		'{'{CMD_RUN,    1'b1, 1'b0, 1'b1, 1'b0}, 1'b0, '0}
	};

	lacp_transmit_rate_limiter_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item (out_item),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic void enter_no_tx();
		lim_ntt = 1'b0;
		lim_count = '0;
		lim_timer = '0;
		lim_state = ST_NO_TX;
	endfunction

	function automatic void enter_reset_count();
		lim_count = '0;
		lim_state = ST_RESET_COUNT;
	endfunction

	function automatic void enter_tx_pdu(input logic mac_up);
		if (mac_up) begin
			step_sent = 1'b1;
			lim_ntt = 1'b0;
			if (lim_timer == '0) begin
				lim_timer = cfg_interval;
				lim_count = CNT_W'(1);
			end else if (lim_count != CNT_MAX) begin
				lim_count = lim_count + 1'b1;
			end
		end
		lim_state = ST_TX_PDU;
	endfunction

	function automatic bit tx_machine_step(input logic enabled, input logic mac_up);
		if (lim_state != ST_NO_TX && !enabled) begin
			enter_no_tx();
			return 1'b1;
		end
		case (lim_state)
			ST_NO_TX: begin
				if (!enabled && lim_ntt) begin
					enter_no_tx();
					return 1'b1;
				end
				if (enabled) begin
					enter_reset_count();
					return 1'b1;
				end
				return 1'b0;
			end
			ST_RESET_COUNT: begin
				if (lim_ntt) begin
					enter_tx_pdu(mac_up);
					return 1'b1;
				end
				return 1'b0;
			end
			ST_TX_PDU: begin
				if (lim_ntt && lim_count < cfg_tx_limit) begin
					enter_tx_pdu(mac_up);
					return 1'b1;
				end
				if (lim_timer == '0) begin
					enter_reset_count();
					return 1'b1;
				end
				return 1'b0;
			end
			default: begin
				enter_no_tx();
				return 1'b1;
			end
		endcase
	endfunction

	function automatic out_item_t predict_item(input in_item_t it);
		out_item_t r;
		int unsigned steps;
		bit took;
		steps = 0;
		step_sent = 1'b0;
		case (it.command)
			CMD_RUN: begin
				if (it.ntt_request)
					lim_ntt = 1'b1;
				while (steps < MAX_RUN_STEPS_DEF) begin
					took = tx_machine_step(it.tx_enabled, it.mac_operational);
					if (!took)
						break;
					steps++;
					if (it.single_step)
						break;
				end
			end
			CMD_TICK: begin
				if (lim_timer != '0)
					lim_timer = lim_timer - 1'b1;
			end
			CMD_RESET: enter_no_tx();
			default: ;
		endcase
		r.tx_state = lim_state;
		r.pdu_sent = step_sent;
		r.transitions = steps[3:0];
		r.ntt_pending = lim_ntt;
		r.sent_count = lim_count;
		return r;
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 62)
			it.command = CMD_RUN;
		else if (pick < 87)
			it.command = CMD_TICK;
		else if (pick < 94)
			it.command = CMD_RESET;
		else
			it.command = CMD_UNUSED;
		it.tx_enabled = ($urandom_range(99) < 90);
		it.ntt_request = 1'($urandom_range(1));
		it.mac_operational = ($urandom_range(99) < 80);
		it.single_step = ($urandom_range(99) < 25);
		return it;
	endfunction

	task automatic note_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch at %0t: %s", $realtime, what);
	endtask

	task automatic send_item(input in_item_t stim, input bit known, input out_item_t want);
		out_item_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= stim;
		do @(posedge clk); while (in_stall);
		predicted = predict_item(stim);
		expected_results.push_back(known ? want : predicted);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== data)
			note_mismatch($sformatf("register %0d reads %0h, wrote %0h", addr, prdata, data));
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_TX_LIMIT)
			cfg_tx_limit = data[3:0];
		else
			cfg_interval = data[TIMER_W-1:0];
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					note_mismatch($sformatf("unexpected result %p", out_item));
				end else begin
					want = expected_results.pop_front();
					if (out_item.tx_state !== want.tx_state
							|| out_item.pdu_sent !== want.pdu_sent
							|| out_item.transitions !== want.transitions
							|| out_item.ntt_pending !== want.ntt_pending
							|| out_item.sent_count !== want.sent_count)
						note_mismatch($sformatf("expected %p, got %p", want, out_item));
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		int phase_limit [PHASES];
		int phase_interval [PHASES];
		int ph;
		phase_limit = '{15, 1, 0, 0, 7};
		phase_interval = '{0, 255, 2, 0, 5};
		phase_limit[3] = $urandom_range(1, 15);
		phase_interval[3] = $urandom_range(0, 255);
		cfg_tx_limit = TX_LIMIT_RST;
		cfg_interval = TX_INTERVAL_RST;
		enter_no_tx();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int k = 0; k < DIR_ROWS; k++)
			send_item(directed_rows[k].stim, directed_rows[k].known, directed_rows[k].want);
		for (ph = 0; ph < PHASES; ph++) begin
			drain();
			write_reg(ADDR_TX_LIMIT, phase_limit[ph]);
			write_reg(ADDR_TX_INTERVAL, phase_interval[ph]);
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 63;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 63;
				end
				default: begin
					send_idle_pct = 33;
					recv_stall_pct = 33;
				end
			endcase
			repeat (ITEMS_PER_PHASE)
				send_item(random_item(), 1'b0, '0);
		end
		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
